[sv/rpcc_pkg.sv]
// Shared constants and types for the rational price compare/convert block.
package rpcc_pkg;

    localparam int AMT_W   = 63;
    localparam int IDENT_W = 32;
    localparam int QUO_W   = 64;
    localparam int PROD_W  = 2 * AMT_W;
    localparam int IN_W    = 480;
    localparam int OUT_W   = 104;

    localparam logic       CMD_COMPARE = 1'b0;
    localparam logic       CMD_CONVERT = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic               vld;
        logic               cmd;
        logic               eq;
        logic               less;
        logic [1:0]         st;
        logic [IDENT_W-1:0] oid;
        logic [AMT_W-1:0]   dv;
        logic [AMT_W-1:0]   rem;
        logic [QUO_W-1:0]   lo;
    } t_cell;

endpackage

[sv/rpcc_front.sv]
// Front end: operand select, split multiplies, product sum, compare and checks.
module rpcc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic                     i_cmd,
    input  logic [rpcc_pkg::IN_W-1:0] i_data,
    output rpcc_pkg::t_cell          o_q
);
    localparam int AW = rpcc_pkg::AMT_W;
    localparam int IW = rpcc_pkg::IDENT_W;
    localparam int PW = rpcc_pkg::PROD_W;

    logic [AW-1:0] amt, fba, fqa, sba, sqa;
    logic [IW-1:0] aid, fbi, fqi, sbi, sqi;

    assign amt = i_data[62:0];
    assign aid = i_data[94:63];
    assign fba = i_data[157:95];
    assign fbi = i_data[189:158];
    assign fqa = i_data[252:190];
    assign fqi = i_data[284:253];
    assign sba = i_data[347:285];
    assign sbi = i_data[379:348];
    assign sqa = i_data[442:380];
    assign sqi = i_data[474:443];

    // stage 1: operand select, ident checks, partial products
    logic [AW-1:0] xa, ya, dv_sel;
    logic [IW-1:0] oid_sel;
    logic [1:0]    st_sel;
    logic          id_eq, id_less;

    always_comb begin
        oid_sel = '0;
        dv_sel  = '0;
        ya      = fba;
        st_sel  = rpcc_pkg::ST_OK;
        if (aid == sbi) begin
            ya = sqa; dv_sel = sba; oid_sel = sqi;
        end else if (aid == sqi) begin
            ya = sba; dv_sel = sqa; oid_sel = sbi;
        end else begin
            st_sel = rpcc_pkg::ST_NO_MATCH;
        end
        if (st_sel == rpcc_pkg::ST_OK && dv_sel == '0) begin
            st_sel = rpcc_pkg::ST_DIV_ZERO;
        end
        if (i_cmd == rpcc_pkg::CMD_COMPARE) begin
            ya = fba;
        end
        xa = (i_cmd == rpcc_pkg::CMD_CONVERT) ? amt : sqa;
        id_eq   = (fbi == sbi) && (fqi == sqi);
        id_less = (fbi < sbi) || ((fbi == sbi) && (fqi < sqi));
    end

    logic          r_v1, r_cmd1, r_ideq1, r_idlt1;
    logic [1:0]    r_st1;
    logic [IW-1:0] r_oid1;
    logic [AW-1:0] r_dv1;
    logic [63:0]   r_all, r_bll;
    logic [62:0]   r_alh, r_ahl, r_blh, r_bhl;
    logic [61:0]   r_ahh, r_bhh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
        end
        if (i_en) begin
            r_cmd1  <= i_cmd;
            r_ideq1 <= id_eq;
            r_idlt1 <= id_less;
            r_st1   <= st_sel;
            r_oid1  <= oid_sel;
            r_dv1   <= dv_sel;
            r_all   <= xa[31:0] * ya[31:0];
            r_alh   <= xa[31:0] * ya[62:32];
            r_ahl   <= xa[62:32] * ya[31:0];
            r_ahh   <= xa[62:32] * ya[62:32];
            r_bll   <= fqa[31:0] * sba[31:0];
            r_blh   <= fqa[31:0] * sba[62:32];
            r_bhl   <= fqa[62:32] * sba[31:0];
            r_bhh   <= fqa[62:32] * sba[62:32];
        end
    end

    // stage 2: sum partial products
    logic          r_v2, r_cmd2, r_ideq2, r_idlt2;
    logic [1:0]    r_st2;
    logic [IW-1:0] r_oid2;
    logic [AW-1:0] r_dv2;
    logic [PW-1:0] r_pa, r_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_cmd2  <= r_cmd1;
            r_ideq2 <= r_ideq1;
            r_idlt2 <= r_idlt1;
            r_st2   <= r_st1;
            r_oid2  <= r_oid1;
            r_dv2   <= r_dv1;
            r_pa <= {62'd0, r_all} + {31'd0, r_alh, 32'd0} + {31'd0, r_ahl, 32'd0}
                  + {r_ahh, 64'd0};
            r_pb <= {62'd0, r_bll} + {31'd0, r_blh, 32'd0} + {31'd0, r_bhl, 32'd0}
                  + {r_bhh, 64'd0};
        end
    end

    // stage 3: cross-product compare, overflow check, seed the divider
    rpcc_pkg::t_cell n_q, r_q;

    always_comb begin
        n_q      = '0;
        n_q.vld  = r_v2;
        n_q.cmd  = r_cmd2;
        n_q.dv   = r_dv2;
        n_q.oid  = r_oid2;
        n_q.rem  = {1'b0, r_pa[PW-1:64]};
        n_q.lo   = r_pa[63:0];
        if (r_cmd2 == rpcc_pkg::CMD_COMPARE) begin
            n_q.eq   = r_ideq2 && (r_pa == r_pb);
            n_q.less = r_ideq2 ? (r_pa < r_pb) : r_idlt2;
        end else begin
            n_q.st = r_st2;
            if (r_st2 == rpcc_pkg::ST_OK && {1'b0, r_pa[PW-1:64]} >= r_dv2) begin
                n_q.st = rpcc_pkg::ST_OVERFLOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

[sv/rpcc_div_cell.sv]
// One restoring-division cell: produces one quotient bit per stage.
module rpcc_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  rpcc_pkg::t_cell i_d,
    output rpcc_pkg::t_cell o_q
);
    localparam int AW = rpcc_pkg::AMT_W;
    localparam int QW = rpcc_pkg::QUO_W;

    logic [AW:0]     shifted, diff;
    logic            ge;
    rpcc_pkg::t_cell n_q, r_q;

    always_comb begin
        shifted = {i_d.rem, i_d.lo[QW-1]};
        ge      = shifted >= {1'b0, i_d.dv};
        diff    = shifted - {1'b0, i_d.dv};
        n_q     = i_d;
        n_q.rem = ge ? diff[AW-1:0] : shifted[AW-1:0];
        n_q.lo  = {i_d.lo[QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

[sv/rational_price_compare_convert.sv]
// Top level of the rational price compare/convert pipeline.
//
// Usage:
//  - Slave channel carries one command item per handshake. tuser is the
//    command: 0 compares the first and second price, 1 converts the asset
//    amount by the second price.
//  - Master channel returns exactly one result item per input item, in order.
//  - Input acceptance to output valid passes through three front
//    stages (operand select with split 32-bit multiplies, product sum, cross
//    compare) and a row of 64 divider cells, one quotient bit per cell.
//  - Throughput is one item per cycle while the receiver does not stall; the whole pipeline advances together.
//  - When the receiver stalls with a result waiting, the pipeline freezes and
//    o_s_tready drops; it rises again the cycle the result is taken.
//  - Reset (synchronous, active low) empties the pipeline; no items are lost
//    other than those in flight at reset.
//  - Convert errors (no ident match, zero divisor, quotient over 64 bits)
//    return amount and ident zero with the status code.
module rational_price_compare_convert (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // tdata: asset_amount, asset_ident, first_base_amount, first_base_ident,
    // first_quote_amount, first_quote_ident, second_base_amount,
    // second_base_ident, second_quote_amount, second_quote_ident, zero pad
    input  logic [rpcc_pkg::IN_W-1:0] i_s_tdata,
    // tuser: command
    input  logic                      i_s_tuser,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // tdata: prices_equal, first_less, converted_amount, converted_ident,
    // status, zero pad
    output logic [rpcc_pkg::OUT_W-1:0] o_m_tdata
);
    localparam int NC = rpcc_pkg::QUO_W;

    logic en;
    rpcc_pkg::t_cell chain [0:NC];
    rpcc_pkg::t_cell last;

    // global advance: move unless a finished result is stuck at the output
    assign en         = !chain[NC].vld || i_m_tready;
    assign o_s_tready = en;

    rpcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_cmd   (i_s_tuser),
        .i_data  (i_s_tdata),
        .o_q     (chain[0])
    );

    // divider row: each cell takes the next dividend bit from its neighbor
    for (genvar g = 0; g < NC; g++) begin : g_cell
        rpcc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (chain[g]),
            .o_q     (chain[g+1])
        );
    end

    assign last = chain[NC];

    logic              ok;
    logic [63:0]       amt_out;
    logic [31:0]       id_out;

    assign ok      = (last.cmd == rpcc_pkg::CMD_CONVERT) && (last.st == rpcc_pkg::ST_OK);
    assign amt_out = ok ? last.lo : 64'd0;
    assign id_out  = ok ? last.oid : 32'd0;

    assign o_m_tvalid = last.vld;
    assign o_m_tdata  = {4'd0, last.st, id_out, amt_out, last.less, last.eq};

    // results of one command never bleed into the other's fields
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (last.vld && last.cmd == rpcc_pkg::CMD_COMPARE) |-> (last.st == rpcc_pkg::ST_OK))
        else $error("compare result carries a status");

    a_eq_less: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last.vld |-> !(last.eq && last.less))
        else $error("equal and less both set");

    a_conv_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (last.vld && last.cmd == rpcc_pkg::CMD_CONVERT) |-> (!last.eq && !last.less))
        else $error("convert result has compare flags");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain[NC].vld && !i_m_tready) |=> $stable(chain[0]))
        else $error("front moved during stall");
endmodule

[tb/tb_rational_price_compare_convert.sv]
// Self-checking testbench for the rational price compare/convert block.
module tb_rational_price_compare_convert;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 1330;
    localparam int WDOG_LIMIT = 20000;
    localparam int TAIL_CYC   = 150;

    typedef struct {
        logic                         cmd;
        logic [rpcc_pkg::AMT_W-1:0]   amt;
        logic [rpcc_pkg::IDENT_W-1:0] aid;
        logic [rpcc_pkg::AMT_W-1:0]   fba;
        logic [rpcc_pkg::IDENT_W-1:0] fbi;
        logic [rpcc_pkg::AMT_W-1:0]   fqa;
        logic [rpcc_pkg::IDENT_W-1:0] fqi;
        logic [rpcc_pkg::AMT_W-1:0]   sba;
        logic [rpcc_pkg::IDENT_W-1:0] sbi;
        logic [rpcc_pkg::AMT_W-1:0]   sqa;
        logic [rpcc_pkg::IDENT_W-1:0] sqi;
    } t_price_op;

    typedef struct {
        logic                         eq;
        logic                         less;
        logic [rpcc_pkg::QUO_W-1:0]   camt;
        logic [rpcc_pkg::IDENT_W-1:0] cid;
        logic [1:0]                   st;
    } t_price_res;

    typedef struct {
        t_price_op  op;
        bit         has_fixed;
        t_price_res fixed;
    } t_stim_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_s_tvalid;
    logic                       o_s_tready;
    logic [rpcc_pkg::IN_W-1:0]  i_s_tdata;   // amt, aid, fba, fbi, fqa, fqi, sba, sbi, sqa, sqi
    logic                       i_s_tuser;   // command
    logic                       o_m_tvalid;
    logic                       i_m_tready;
    logic [rpcc_pkg::OUT_W-1:0] o_m_tdata;   // eq, less, camt, cid, st

    t_price_res expected_q[$];
    int  n_errors;
    int  idle_cycles;
    bit  no_idle;        // stretch without random gaps
    bit  rx_hold;        // long receiver hold-off request

    rational_price_compare_convert dut (.*);

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    function automatic logic [rpcc_pkg::IN_W-1:0] pack_op(t_price_op o);
        return rpcc_pkg::IN_W'({o.sqi, o.sqa, o.sbi, o.sba, o.fqi, o.fqa, o.fbi, o.fba,
                                o.aid, o.amt});
    endfunction

    // Expected result of one command.
    function automatic t_price_res price_predict(t_price_op o);
        t_price_res r;
        logic [rpcc_pkg::PROD_W-1:0] am, bm;
        logic [127:0] prod;
        logic [rpcc_pkg::AMT_W-1:0] mulv, dv;
        logic [rpcc_pkg::IDENT_W-1:0] oid;
        r = '{default: '0};
        if (o.cmd == rpcc_pkg::CMD_COMPARE) begin
            am = rpcc_pkg::PROD_W'(o.sqa) * rpcc_pkg::PROD_W'(o.fba);
            bm = rpcc_pkg::PROD_W'(o.fqa) * rpcc_pkg::PROD_W'(o.sba);
            if (o.fbi != o.sbi) begin
                r.less = o.fbi < o.sbi;
            end else if (o.fqi != o.sqi) begin
                r.less = o.fqi < o.sqi;
            end else begin
                r.eq   = am == bm;
                r.less = am < bm;
            end
        end else begin
            if (o.aid == o.sbi) begin
                mulv = o.sqa; dv = o.sba; oid = o.sqi;
            end else if (o.aid == o.sqi) begin
                mulv = o.sba; dv = o.sqa; oid = o.sbi;
            end else begin
                r.st = rpcc_pkg::ST_NO_MATCH;
                return r;
            end
            if (dv == 0) begin
                r.st = rpcc_pkg::ST_DIV_ZERO;
            end else begin
                prod = 128'(o.amt) * 128'(mulv);
                if (prod[127:64] >= 64'(dv)) begin
                    r.st = rpcc_pkg::ST_OVERFLOW;
                end else begin
                    r.camt = rpcc_pkg::QUO_W'(prod / 128'(dv));
                    r.cid  = oid;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [rpcc_pkg::AMT_W-1:0] rand_amt();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return rpcc_pkg::AMT_W'($urandom_range(0, 1000));
            3: return rpcc_pkg::AMT_W'($urandom) << $urandom_range(0, 31);
            default: return rpcc_pkg::AMT_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic t_price_op rand_op();
        t_price_op o;
        logic [rpcc_pkg::IDENT_W-1:0] pool[4];
        for (int k = 0; k < 4; k++) pool[k] = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
        o.cmd = 1'($urandom_range(0, 1));
        o.amt = rand_amt(); o.fba = rand_amt(); o.fqa = rand_amt();
        o.sba = rand_amt(); o.sqa = rand_amt();
        // mostly shared identifiers so the deep branches are reached
        o.fbi = pool[$urandom_range(0, 1)];
        o.fqi = pool[$urandom_range(1, 2)];
        o.sbi = ($urandom_range(0, 3) != 0) ? o.fbi : pool[$urandom_range(0, 3)];
        o.sqi = ($urandom_range(0, 3) != 0) ? o.fqi : pool[$urandom_range(0, 3)];
        case ($urandom_range(0, 4))
            0: o.aid = o.sqi;
            1: o.aid = $urandom;
            default: o.aid = o.sbi;
        endcase
        if (o.cmd == rpcc_pkg::CMD_COMPARE && $urandom_range(0, 3) == 0) begin
            // equal ratio: first and second price set to the same even amounts
            o.fba = o.sba >> 1; o.fqa = o.sqa >> 1;
            o.fba = o.fba << 1; o.fqa = o.fqa << 1;
            o.sba = o.fba; o.sqa = o.fqa;
        end
        return o;
    endfunction

    // Offer one item and hold it until it is taken; valid drops only in a gap.
    task automatic send_op(t_price_op o, bit has_fixed, t_price_res fixed);
        while (!no_idle && $urandom_range(0, 99) < 16) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pack_op(o);
        i_s_tuser  <= o.cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_q.push_back(has_fixed ? fixed : price_predict(o));
    endtask

    // Receiver: random stalls, one long hold-off on request.
    initial begin
        int hold;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold) begin
                i_m_tready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            i_m_tready <= no_idle || ($urandom_range(0, 99) >= 16);
            @(posedge i_clk);
        end
    end

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        t_price_res got, want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.eq   = o_m_tdata[0];
                got.less = o_m_tdata[1];
                got.camt = o_m_tdata[2 +: rpcc_pkg::QUO_W];
                got.cid  = o_m_tdata[66 +: rpcc_pkg::IDENT_W];
                got.st   = o_m_tdata[98 +: 2];
                if (expected_q.size() == 0) begin
                    $error("result item with nothing expected");
                    n_errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.eq !== want.eq) begin
                        $error("prices_equal exp %0d got %0d", want.eq, got.eq); n_errors++;
                    end
                    if (got.less !== want.less) begin
                        $error("first_less exp %0d got %0d", want.less, got.less); n_errors++;
                    end
                    if (got.camt !== want.camt) begin
                        $error("converted_amount exp %0h got %0h", want.camt, got.camt);
                        n_errors++;
                    end
                    if (got.cid !== want.cid) begin
                        $error("converted_ident exp %0h got %0h", want.cid, got.cid);
                        n_errors++;
                    end
                    if (got.st !== want.st) begin
                        $error("status exp %0d got %0d", want.st, got.st); n_errors++;
                    end
                end
            end
        end
    end

    initial begin
        t_stim_row  rows[$];
        t_price_op  o;
        t_price_res z;
        n_errors   = 0;
        no_idle    = 1'b0;
        rx_hold    = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        z = '{default: '0};
        // directed table
        o = '{default: '0};
        rows.push_back('{o, 1, '{1, 0, 0, 0, rpcc_pkg::ST_OK}});        // all zero compare
        o.cmd = rpcc_pkg::CMD_CONVERT;
        rows.push_back('{o, 1, '{0, 0, 0, 0, rpcc_pkg::ST_DIV_ZERO}});  // zero divisor
        o.aid = 5;
        rows.push_back('{o, 1, '{0, 0, 0, 0, rpcc_pkg::ST_NO_MATCH}});  // no side matches
        o = '{cmd: rpcc_pkg::CMD_CONVERT, amt: '1, aid: '1, fba: '1, fbi: '1, fqa: '1,
              fqi: '1, sba: 1, sbi: '1, sqa: '1, sqi: 7, default: '0};
        rows.push_back('{o, 1, '{0, 0, 0, 0, rpcc_pkg::ST_OVERFLOW}});  // quotient too wide
        o.sba = '1;
        rows.push_back('{o, 0, z});                                    // max / max
        o.sbi = 3; o.sqi = '1; o.sba = 2; o.sqa = '1;
        rows.push_back('{o, 0, z});                                    // quote side match
        o.sbi = '1;
        rows.push_back('{o, 0, z});                                    // both sides: base wins
        o = '{cmd: rpcc_pkg::CMD_COMPARE, fba: '1, fqa: '1, sba: '1, sqa: '1, fbi: '1,
              fqi: '1, sbi: '1, sqi: '1, default: '0};
        rows.push_back('{o, 1, '{1, 0, 0, 0, rpcc_pkg::ST_OK}});        // equal extremes
        o.fbi = 0;
        rows.push_back('{o, 1, '{0, 1, 0, 0, rpcc_pkg::ST_OK}});        // lower base id
        o.fbi = '1; o.fqi = 0;
        rows.push_back('{o, 1, '{0, 1, 0, 0, rpcc_pkg::ST_OK}});        // lower quote id
        o.fqi = '1; o.sqi = 0;
        rows.push_back('{o, 1, '{0, 0, 0, 0, rpcc_pkg::ST_OK}});        // higher quote id
        o.sqi = '1; o.fqa = 3;
        rows.push_back('{o, 0, z});                                    // cross product
        o.fqa = '1; o.fba = 3;
        rows.push_back('{o, 0, z});
        for (int k = 0; k < 6; k++) rows.push_back('{rand_op(), 0, z});
        foreach (rows[k]) send_op(rows[k].op, rows[k].has_fixed, rows[k].fixed);

        for (int n = 0; n < N_RANDOM; n++) begin
            no_idle = (n >= 200 && n < 400);
            if (n == 500) rx_hold = 1'b1;            // fill up and stall input
            if (n == 900) begin
                i_s_tvalid <= 1'b0;
                while (expected_q.size() != 0) @(posedge i_clk);
            end
            send_op(rand_op(), 0, z);
        end
        i_s_tvalid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

[files.f]
sv/rpcc_pkg.sv
sv/rpcc_front.sv
sv/rpcc_div_cell.sv
sv/rational_price_compare_convert.sv
tb/tb_rational_price_compare_convert.sv
